### hw/rtl/psipp_pkg.sv
// shared types and constants for the psi section pat/pmt parser
`timescale 1ns / 1ps

package psipp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_start;
   } req_type;

   typedef struct packed {
      logic        entry_kind;
      logic [15:0] table_ident;
      logic [4:0]  table_version;
      logic [15:0] entry_number;
      logic [7:0]  stream_kind;
      logic [12:0] entry_pid;
      logic        last_entry;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_PAT  = 2'd1,
      MODE_PMT  = 2'd2
   } mode_type;

   localparam logic [7:0]  TID_PAT    = 8'h00;
   localparam logic [7:0]  TID_PMT    = 8'h02;
   localparam logic        KIND_PAT   = 1'b0;
   localparam logic        KIND_PMT   = 1'b1;
   localparam logic [11:0] LOOP_START = 12'd8;

   localparam logic [11:0] POS_LEN_HI   = 12'd1;
   localparam logic [11:0] POS_LEN_LO   = 12'd2;
   localparam logic [11:0] POS_IDENT_HI = 12'd3;
   localparam logic [11:0] POS_IDENT_LO = 12'd4;
   localparam logic [11:0] POS_VERSION  = 12'd5;
   localparam logic [11:0] POS_INFO_HI  = 12'd10;
   localparam logic [11:0] POS_INFO_LO  = 12'd11;

endpackage

### hw/rtl/psipp_parser.sv
// section byte parser: per-section state and entry extraction
`timescale 1ns / 1ps

module psipp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  psipp_pkg::req_type beat,
   output logic              emit,
   output psipp_pkg::rsp_type result
);
   import psipp_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [11:0] pos_ff, pos_in;
   logic [11:0] slen_ff, slen_in;
   logic [11:0] info_ff, info_in;
   logic [15:0] ident_ff, ident_in;
   logic [4:0]  version_ff, version_in;
   logic [2:0]  ebi_ff, ebi_in;
   logic [15:0] num_ff, num_in;
   logic [7:0]  skind_ff, skind_in;
   logic [12:0] pid_ff, pid_in;
   logic [11:0] skip_ff, skip_in;

   logic [7:0]  b;
   logic        active;
   logic        end_hit;
   logic        work;
   logic [11:0] info_lo;

   assign b       = beat.data_byte;
   assign active  = (mode_ff == MODE_PAT) || (mode_ff == MODE_PMT);
   assign end_hit = (pos_ff >= LOOP_START) &&
                    (({1'b0, pos_ff} + 13'd1) >= {1'b0, slen_ff});
   assign work    = fire && !beat.section_start && active && !end_hit;
   assign info_lo = {info_ff[11:8], b};

   // mode next state
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         if (beat.section_start) begin
            priority if (b == TID_PAT) begin
               mode_in = MODE_PAT;
            end else if (b == TID_PMT) begin
               mode_in = MODE_PMT;
            end else begin
               mode_in = MODE_IDLE;
            end
         end else if (active && end_hit) begin
            mode_in = MODE_IDLE;
         end
      end
   end

   // field updates and result
   always_comb begin
      pos_in     = pos_ff;
      slen_in    = slen_ff;
      info_in    = info_ff;
      ident_in   = ident_ff;
      version_in = version_ff;
      ebi_in     = ebi_ff;
      num_in     = num_ff;
      skind_in   = skind_ff;
      pid_in     = pid_ff;
      skip_in    = skip_ff;
      emit       = 1'b0;
      result.entry_kind    = KIND_PAT;
      result.table_ident   = ident_ff;
      result.table_version = version_ff;
      result.entry_number  = num_ff;
      result.stream_kind   = 8'd0;
      result.entry_pid     = {pid_ff[12:8], b};
      result.last_entry    = 1'b0;

      if (fire && beat.section_start) begin
         ebi_in  = 3'd0;
         skip_in = 12'd0;
         pos_in  = 12'd1;
      end else if (work) begin
         pos_in = pos_ff + 12'd1;
         priority if (pos_ff == POS_LEN_HI) begin
            slen_in = {b[3:0], 8'd0};
         end else if (pos_ff == POS_LEN_LO) begin
            slen_in = {slen_ff[11:8], b};
         end else if (pos_ff == POS_IDENT_HI) begin
            ident_in = {b, 8'd0};
         end else if (pos_ff == POS_IDENT_LO) begin
            ident_in = {ident_ff[15:8], b};
         end else if (pos_ff == POS_VERSION) begin
            version_in = b[5:1];
         end else if (pos_ff < LOOP_START) begin
            // section number bytes
         end else if (mode_ff == MODE_PAT) begin
            unique case (ebi_ff)
               3'd0: begin
                  num_in = {b, 8'd0};
                  ebi_in = 3'd1;
               end
               3'd1: begin
                  num_in = {num_ff[15:8], b};
                  ebi_in = 3'd2;
               end
               3'd2: begin
                  pid_in = {b[4:0], 8'd0};
                  ebi_in = 3'd3;
               end
               default: begin
                  pid_in = {pid_ff[12:8], b};
                  ebi_in = 3'd0;
                  emit   = 1'b1;
                  result.last_entry = (({1'b0, pos_ff} + 13'd5) >= {1'b0, slen_ff});
               end
            endcase
         end else if (pos_ff < POS_INFO_HI) begin
            // pcr pid bytes
         end else if (pos_ff == POS_INFO_HI) begin
            info_in = {b[3:0], 8'd0};
         end else if (pos_ff == POS_INFO_LO) begin
            info_in = info_lo;
            skip_in = info_lo;
            ebi_in  = 3'd0;
         end else if (skip_ff != 12'd0) begin
            skip_in = skip_ff - 12'd1;
         end else begin
            unique case (ebi_ff)
               3'd0: begin
                  skind_in = b;
                  ebi_in   = 3'd1;
               end
               3'd1: begin
                  pid_in = {b[4:0], 8'd0};
                  ebi_in = 3'd2;
               end
               3'd2: begin
                  pid_in = {pid_ff[12:8], b};
                  ebi_in = 3'd3;
               end
               3'd3: begin
                  info_in = {b[3:0], 8'd0};
                  ebi_in  = 3'd4;
               end
               default: begin
                  info_in = info_lo;
                  skip_in = info_lo;
                  ebi_in  = 3'd0;
                  emit    = 1'b1;
                  result.entry_kind   = KIND_PMT;
                  result.entry_number = 16'd0;
                  result.stream_kind  = skind_ff;
                  result.entry_pid    = pid_ff;
                  result.last_entry   = (({2'b0, pos_ff} + 14'd6 + {2'b0, info_lo})
                                         >= {2'b0, slen_ff});
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pos_ff     <= 12'd0;
         slen_ff    <= 12'd0;
         info_ff    <= 12'd0;
         ident_ff   <= 16'd0;
         version_ff <= 5'd0;
         ebi_ff     <= 3'd0;
         num_ff     <= 16'd0;
         skind_ff   <= 8'd0;
         pid_ff     <= 13'd0;
         skip_ff    <= 12'd0;
      end else begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         slen_ff    <= slen_in;
         info_ff    <= info_in;
         ident_ff   <= ident_in;
         version_ff <= version_in;
         ebi_ff     <= ebi_in;
         num_ff     <= num_in;
         skind_ff   <= skind_in;
         pid_ff     <= pid_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

### hw/rtl/psipp_out_reg.sv
// result register with stall handling
`timescale 1ns / 1ps

module psipp_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               emit,
   input  psipp_pkg::rsp_type result,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output psipp_pkg::rsp_type rsp_data,
   output logic               blocked
);
   import psipp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign blocked  = valid_ff && rsp_stall;
   assign valid_in = blocked || (advance && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### hw/rtl/psi_section_pat_pmt_parser_top.sv
// top level of the psi section pat/pmt parser
//
// req channel: one section byte per beat, section_start marks the table id
// byte. table id 0x00 parses a pat, 0x02 a pmt, anything else is dropped
// until the next start. the crc is never checked.
// rsp channel: one beat per pat program entry or pmt elementary stream
// entry, last_entry set on the final complete entry of the section.
// a byte is registered in the input register and parsed on the way into the
// result register; rsp_valid comes from the result register, which loads
// as the byte completing the entry leaves the input register.
// throughput: one byte per cycle while the result register is not stalled,
// set by the single parse step between the input and result registers.
// stall: the result register holds while it is valid and rsp_stall is high;
// a byte waiting in the input register then holds too and req_stall rises.
// reset: both registers empty, parser idle until the next section start.
`timescale 1ns / 1ps

module psi_section_pat_pmt_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  psipp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psipp_pkg::rsp_type rsp_data
);
   import psipp_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    blocked;
   logic    advance;
   logic    emit;
   rsp_type result;

   assign advance     = in_valid_ff && !blocked;
   assign req_stall   = in_valid_ff && blocked;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   psipp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .beat   (in_data_ff),
      .emit   (emit),
      .result (result)
   );

   psipp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .emit      (emit),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .blocked   (blocked)
   );

endmodule
